[rtl/phe_pkg.sv]
// ---------------------------------------------------------------------------
// phe_pkg
// Shared types and constants for the Horner polynomial evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package phe_pkg;

    localparam int DATA_W       = 32;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int NUM_COEFFS   = 8;
    localparam int COEFF_IDX_W  = $clog2(NUM_COEFFS);
    localparam int CFG_INDEX_W  = COEFF_IDX_W + 1;
    localparam int DEF_DEGREE   = 7;
    localparam int DEF_FRAC     = 16;

    typedef struct packed {
        logic                     valid;
        logic                     sat;
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] x;
    } t_lane;

    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] value;
    } t_result;

endpackage

`default_nettype wire

[rtl/phe_cell.sv]
// ---------------------------------------------------------------------------
// phe_cell
// One Horner step: registered multiply, then shift, add and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module phe_cell #(
    parameter int FRAC_BITS = phe_pkg::DEF_FRAC
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  wire logic signed [phe_pkg::DATA_W-1:0] i_coeff,
    input  wire phe_pkg::t_lane                 i_lane,
    output phe_pkg::t_lane                      o_lane
);

    localparam int SUM_W = phe_pkg::PROD_W + 1;

    logic                                 r_mul_valid;
    logic                                 r_mul_sat;
    logic signed [phe_pkg::PROD_W-1:0]    r_prod;
    logic signed [phe_pkg::DATA_W-1:0]    r_mul_x;
    logic signed [phe_pkg::PROD_W-1:0]    n_prod;

    logic signed [phe_pkg::PROD_W-1:0]    shifted;
    logic signed [SUM_W-1:0]              sum;
    logic                                 over;
    logic                                 under;
    logic signed [phe_pkg::DATA_W-1:0]    n_acc;

    phe_pkg::t_lane r_lane;

    assign n_prod = i_lane.acc * i_lane.x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (i_en) begin
            r_mul_valid <= i_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod    <= n_prod;
            r_mul_x   <= i_lane.x;
            r_mul_sat <= i_lane.sat;
        end
    end

    always_comb begin
        shifted = r_prod >>> FRAC_BITS;
        sum     = SUM_W'(shifted) + SUM_W'(i_coeff);
        over    = !sum[SUM_W-1] && (sum[SUM_W-2:phe_pkg::DATA_W-1] != '0);
        under   = sum[SUM_W-1] && (sum[SUM_W-2:phe_pkg::DATA_W-1] != '1);
        if (over) begin
            n_acc = {1'b0, {(phe_pkg::DATA_W-1){1'b1}}};
        end else if (under) begin
            n_acc = {1'b1, {(phe_pkg::DATA_W-1){1'b0}}};
        end else begin
            n_acc = sum[phe_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane.valid <= r_mul_valid;
        end
        if (i_en) begin
            r_lane.acc <= n_acc;
            r_lane.x   <= r_mul_x;
            r_lane.sat <= r_mul_sat | over | under;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

[rtl/phe_out_skid.sv]
// ---------------------------------------------------------------------------
// phe_out_skid
// Output register with one skid entry; stalls the cell chain when full.
// ---------------------------------------------------------------------------
`default_nettype none

module phe_out_skid (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire phe_pkg::t_result i_data,
    output logic                o_ready,
    output logic                o_valid,
    output phe_pkg::t_result    o_data,
    input  wire                 i_ready
);

    logic               r_out_valid;
    phe_pkg::t_result   r_out_data;
    logic               r_skid_valid;
    phe_pkg::t_result   r_skid_data;
    logic               take;

    assign o_ready = !r_skid_valid;
    assign take    = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= take;
            end
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else begin
                r_out_data <= i_data;
            end
        end else if (take) begin
            r_skid_data <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

[rtl/polynomial_horner_eval_core.sv]
// ---------------------------------------------------------------------------
// polynomial_horner_eval_core
// Q16.16 polynomial evaluation by Horner's rule over a chain of
// multiply-add cells, one cell per step.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                    | word
//  s_axis  | in        | s_axis_tvalid/s_axis_tready  | tdata: sample_x
//  m_axis  | out       | m_axis_tvalid/m_axis_tready  | tdata: poly_value, tuser: saturated
//  cfg     | in        | i_cfg_valid/o_cfg_ready      | index, coefficient
//
//  One sample per cycle while the chain is not held; two registers per
//  cell (a 32x32 multiply then shift/add/saturate), plus the output register.
//  Reset clears the coefficients and all valid bits.
//  A stall on m_axis fills one skid entry, then holds the whole chain.
// ---------------------------------------------------------------------------
`default_nettype none

module polynomial_horner_eval_core #(
    parameter int DEGREE    = phe_pkg::DEF_DEGREE,
    parameter int FRAC_BITS = phe_pkg::DEF_FRAC
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [phe_pkg::DATA_W-1:0]            s_axis_tdata,   // [31:0] sample_x
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [phe_pkg::DATA_W-1:0]            m_axis_tdata,   // [31:0] poly_value
    output logic                                  m_axis_tuser,   // [0] saturated
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [phe_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire  [phe_pkg::DATA_W-1:0]            i_cfg_data
);

    logic signed [phe_pkg::DATA_W-1:0] r_coeff [phe_pkg::NUM_COEFFS];

    phe_pkg::t_lane   lane [DEGREE+1];
    phe_pkg::t_result chain_result;
    logic             en;
    logic             out_valid;
    phe_pkg::t_result out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < phe_pkg::NUM_COEFFS; k++) begin
                r_coeff[k] <= '0;
            end
        end else if (i_cfg_valid && !i_cfg_index[phe_pkg::CFG_INDEX_W-1]) begin
            r_coeff[i_cfg_index[phe_pkg::COEFF_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    assign s_axis_tready = en;

    assign lane[0] = '{valid: s_axis_tvalid,
                       sat:   1'b0,
                       acc:   r_coeff[DEGREE],
                       x:     s_axis_tdata};

    for (genvar g = 0; g < DEGREE; g++) begin : g_cell
        phe_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_coeff (r_coeff[DEGREE-1-g]),
            .i_lane  (lane[g]),
            .o_lane  (lane[g+1])
        );
    end

    assign chain_result.sat   = lane[DEGREE].sat;
    assign chain_result.value = lane[DEGREE].acc;

    phe_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lane[DEGREE].valid),
        .i_data  (chain_result),
        .o_ready (en),
        .o_valid (out_valid),
        .o_data  (out_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = out_data.value;
    assign m_axis_tuser  = out_data.sat;

endmodule

`default_nettype wire

[verif/horner_eval_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// horner_eval_checker
// Watches the sample, result and coefficient channels of the Horner
// evaluator, keeps its own coefficient copy, predicts p(x) with the
// saturation flag for every accepted sample and compares each accepted
// result, in order, against the oldest prediction.
// ---------------------------------------------------------------------------

module horner_eval_checker #(
    parameter int DEGREE    = phe_pkg::DEF_DEGREE,
    parameter int FRAC_BITS = phe_pkg::DEF_FRAC
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    input  wire                              i_s_tready,
    input  wire  [phe_pkg::DATA_W-1:0]       i_s_tdata,
    input  wire                              i_m_tvalid,
    input  wire                              i_m_tready,
    input  wire  [phe_pkg::DATA_W-1:0]       i_m_tdata,
    input  wire                              i_m_tuser,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_ready,
    input  wire  [phe_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire  [phe_pkg::DATA_W-1:0]       i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import phe_pkg::*;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic signed [DATA_W-1:0] coeff_reg [NUM_COEFFS];
    t_result                  poly_expected_q [$];
    int                       mismatch_cnt = 0;

    assign o_fail_count = mismatch_cnt;

    function automatic t_result horner_eval(input logic signed [DATA_W-1:0] x);
        longint  acc;
        longint  sum;
        t_result r;
        acc   = longint'(coeff_reg[DEGREE]);
        r.sat = 1'b0;
        for (int i = DEGREE - 1; i >= 0; i--) begin
            sum = ((acc * longint'(x)) >>> FRAC_BITS) + longint'(coeff_reg[i]);
            if (sum > SAT_HI) begin
                sum   = SAT_HI;
                r.sat = 1'b1;
            end else if (sum < SAT_LO) begin
                sum   = SAT_LO;
                r.sat = 1'b1;
            end
            acc = sum;
        end
        r.value = acc[DATA_W-1:0];
        return r;
    endfunction

    task automatic log_fail(input string msg);
        if (mismatch_cnt < 10) $display("[%0t] checker: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            foreach (coeff_reg[i]) coeff_reg[i] = '0;
            poly_expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_COEFFS)
                coeff_reg[i_cfg_index[COEFF_IDX_W-1:0]] = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                poly_expected_q.push_back(horner_eval(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata;
                got.sat   = i_m_tuser;
                if (poly_expected_q.size() == 0) begin
                    log_fail($sformatf("unexpected word value=%h sat=%b",
                                       got.value, got.sat));
                end else begin
                    want = poly_expected_q.pop_front();
                    if (got.value !== want.value || got.sat !== want.sat)
                        log_fail($sformatf("value exp=%h got=%h  sat exp=%b got=%b",
                                           want.value, got.value, want.sat, got.sat));
                end
            end
            o_pending <= poly_expected_q.size();
        end
    end

endmodule

[verif/tb_polynomial_horner_eval_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_polynomial_horner_eval_core
// Drives samples and coefficient sets into the Horner evaluator: a directed
// pass over extreme values and saturation cases, then random bursts under
// three idling profiles, with a long output hold-off that backs up the
// chain. A side checker predicts and compares every result word.
// ---------------------------------------------------------------------------

module tb_polynomial_horner_eval_core;
    import phe_pkg::*;

    localparam int DEGREE         = DEF_DEGREE;
    localparam int FRAC_BITS      = DEF_FRAC;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BURSTS         = 6;
    localparam int BURST_ITEMS    = 100;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic [DATA_W-1:0]      s_axis_tdata  = '0;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [DATA_W-1:0]      i_cfg_data    = '0;
    wire                    s_axis_tready;
    wire                    m_axis_tvalid;
    wire  [DATA_W-1:0]      m_axis_tdata;
    wire                    m_axis_tuser;
    wire                    o_cfg_ready;

    int                     fail_count;
    int                     pending;
    int unsigned            send_idle_pct = 32;
    int unsigned            recv_idle_pct = 81;
    int unsigned            hold_req      = 0;
    int unsigned            hold_ack      = 0;
    int unsigned            hold_left     = 0;
    int unsigned            stall_cycles  = 0;
    logic [DATA_W-1:0]      coeff_plan [NUM_COEFFS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    polynomial_horner_eval_core #(
        .DEGREE    (DEGREE),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    horner_eval_checker #(
        .DEGREE    (DEGREE),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: random back-pressure, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            m_axis_tready <= 1'b0;
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_q16(input int unsigned zero_pct);
        int unsigned pick;
        int          mag;
        pick = $urandom_range(99);
        if (pick < zero_pct) return '0;
        if (pick < zero_pct + 8) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (pick < zero_pct + 25) return $urandom();
        mag = int'($urandom_range(32'd1 << $urandom_range(18, 4)));
        return $urandom_range(1) ? DATA_W'(-mag) : DATA_W'(mag);
    endfunction

    task automatic push_sample(input logic [DATA_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // load the plan, then poke unmapped indexes, which must be dropped
    task automatic load_coefficients(input int unsigned stray_writes);
        for (int i = 0; i < NUM_COEFFS; i++)
            write_reg(CFG_INDEX_W'(i), coeff_plan[i]);
        repeat (stray_writes)
            write_reg(CFG_INDEX_W'(NUM_COEFFS + $urandom_range(NUM_COEFFS - 1)), $urandom());
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_sample_burst(input int unsigned n, input bit long_hold);
        wait_results_drained();
        for (int i = 0; i < NUM_COEFFS; i++) coeff_plan[i] = rand_q16(25);
        load_coefficients($urandom_range(1));
        if (long_hold) hold_req <= hold_req + 1;
        repeat (n) push_sample(rand_q16(5));
    endtask

    initial begin
        int unsigned send_pct [3];
        int unsigned recv_pct [3];
        send_pct = '{32, 81, 0};
        recv_pct = '{81, 32, 0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coefficients still at reset: every result is zero
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);

        // p(x) = 1 + 2x - 0.5x^2
        wait_results_drained();
        foreach (coeff_plan[i]) coeff_plan[i] = '0;
        coeff_plan[0] = 32'h0001_0000;
        coeff_plan[1] = 32'h0002_0000;
        coeff_plan[2] = 32'hFFFF_8000;
        load_coefficients(0);
        push_sample(32'h0000_0000);
        push_sample(32'h0001_0000);
        push_sample(32'hFFFF_0000);
        push_sample(32'h0000_0001);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);

        // all coefficients at the positive limit
        wait_results_drained();
        foreach (coeff_plan[i]) coeff_plan[i] = 32'h7FFF_FFFF;
        load_coefficients(0);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0000);

        // all coefficients at the negative limit
        wait_results_drained();
        foreach (coeff_plan[i]) coeff_plan[i] = 32'h8000_0000;
        load_coefficients(0);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0001_0000);

        // pure x^7, with writes to unmapped indexes
        wait_results_drained();
        foreach (coeff_plan[i]) coeff_plan[i] = '0;
        coeff_plan[DEGREE] = 32'h0001_0000;
        load_coefficients(2);
        push_sample(32'h0002_0000);
        push_sample(32'hFFFE_0000);
        push_sample(32'h0100_0000);
        push_sample(32'h0000_8000);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct =  send_pct[ph];
            recv_idle_pct <= recv_pct[ph];
            for (int b = 0; b < BURSTS; b++)
                run_sample_burst(BURST_ITEMS, (ph == 2) && (b == 1));
        end

        wait_results_drained();
        repeat (2 * DEGREE + 4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
